// ===== rtl/rslm_pkg.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter package
// Shared widths, register reset values, register indexes and types.
// ----------------------------------------------------------------------------
package rslm_pkg;

    // Default sizing of the block
    localparam int DEF_MAX_WINDOW  = 256;
    localparam int DEF_SAMPLE_BITS = 12;

    // Configuration register widths and reset values
    localparam int CFG_WINDOW_W    = 9;
    localparam int CFG_VOLTS_W     = 18;
    localparam int CFG_WEIGHT_W    = 9;
    localparam int CFG_DATA_W      = 18;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [CFG_WINDOW_W-1:0] RST_WINDOW_LENGTH   = 9'd200;
    localparam logic [CFG_VOLTS_W-1:0]  RST_NOISE_THRESHOLD = 18'd6554;
    localparam logic [CFG_VOLTS_W-1:0]  RST_LEVEL_STEP      = 18'd2163;
    localparam logic [CFG_WEIGHT_W-1:0] RST_NEW_WEIGHT      = 9'd179;

    // Result and datapath widths
    localparam int LEVEL_W       = 8;
    localparam int VOLTS_W       = 18;
    localparam int SUM_W         = 32;
    localparam int DIVISOR_W     = 18;
    localparam int OUT_TDATA_W   = 32;
    localparam int OUT_PAD_W     = OUT_TDATA_W - VOLTS_W - LEVEL_W;
    localparam int PRODUCT_W     = VOLTS_W + CFG_WEIGHT_W;
    localparam int QUEUE_DEPTH   = 2;
    localparam int SQRT_STEPS    = SUM_W / 2;

    // Arithmetic constants of the amplitude and smoothing math
    localparam logic [VOLTS_W-1:0]      VOLTS_MAX  = '1;
    localparam logic [LEVEL_W-1:0]      LEVEL_MAX  = '1;
    localparam logic [CFG_WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam int VOLT_NUM_BASE = 33;      // 3.3 V scaled by ten
    localparam int VOLT_ROUND    = 5;       // half of the denominator
    localparam int Q16_SHIFT     = 16;
    localparam int SMOOTH_ROUND  = 128;
    localparam int SMOOTH_SHIFT  = 8;

    // Divide by ten as a multiply by ceil(2^26 / 10) and a shift by 26.
    // The result is exact for every numerator below 2^26 / 6, and the volt
    // numerator never exceeds about 2.2 million.
    localparam int                      VOLT_RECIP_W     = 23;
    localparam logic [VOLT_RECIP_W-1:0] VOLT_RECIP       = 23'd6710887;
    localparam int                      VOLT_RECIP_SHIFT = 26;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH   = 2'd0,
        CFG_NOISE_THRESHOLD = 2'd1,
        CFG_LEVEL_STEP      = 2'd2,
        CFG_NEW_WEIGHT      = 2'd3
    } t_cfg_index;

    // Configuration register file contents
    typedef struct packed {
        logic [CFG_WINDOW_W-1:0] window_length;
        logic [CFG_VOLTS_W-1:0]  noise_threshold;
        logic [CFG_VOLTS_W-1:0]  level_step;
        logic [CFG_WEIGHT_W-1:0] new_weight;
    } t_cfg;

    // Back end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MEAN,
        BK_SQRT,
        BK_SCALE,
        BK_VOLT,
        BK_MIX,
        BK_SUM,
        BK_LEVEL,
        BK_EMIT
    } t_back_state;

endpackage

// ===== rtl/rslm_front.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter front end
// Squares each sample item, accumulates the window and hands finished
// windows (sum of squares and sample count) to the window queue.
// ----------------------------------------------------------------------------
module rslm_front import rslm_pkg::*; #(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    input  logic [CFG_WINDOW_W-1:0]            i_window_length,
    input  logic                               i_queue_full,
    output logic                               o_push,
    output logic [SUM_W-1:0]                   o_push_sum,
    output logic [$clog2(MAX_WINDOW+1)-1:0]    o_push_count
);

    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W    = 2 * SAMPLE_BITS;

    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;

    logic [COUNT_W-1:0] w_len;
    logic [COUNT_W-1:0] w_count_next;
    logic [SQ_W-1:0]    w_square;
    logic [SUM_W:0]     w_sum_wide;
    logic [SUM_W-1:0]   w_sum_next;
    logic               w_end;
    logic               w_accept;

    // Effective window length: zero counts as one, long windows saturate.
    always_comb begin
        if (i_window_length == '0) begin
            w_len = COUNT_W'(1);
        end else if (32'(i_window_length) > 32'(MAX_WINDOW)) begin
            w_len = COUNT_W'(MAX_WINDOW);
        end else begin
            w_len = COUNT_W'(i_window_length);
        end
    end

    // Square and saturating accumulate.
    assign w_square     = SQ_W'(i_sample) * SQ_W'(i_sample);
    assign w_sum_wide   = {1'b0, r_sum} + (SUM_W + 1)'(w_square);
    assign w_sum_next   = w_sum_wide[SUM_W] ? '1 : w_sum_wide[SUM_W-1:0];
    assign w_count_next = r_count + COUNT_W'(1);
    assign w_end        = (w_count_next >= w_len);

    // Only an item that closes a window needs room in the queue.
    assign o_ready  = !(w_end && i_queue_full);
    assign w_accept = i_valid && o_ready;

    assign o_push       = w_accept && w_end;
    assign o_push_sum   = w_sum_next;
    assign o_push_count = w_count_next;

    // Window accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            if (w_end) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= w_sum_next;
                r_count <= w_count_next;
            end
        end
    end

endmodule

// ===== rtl/rslm_queue.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter window queue
// Short register FIFO that decouples window accumulation from window math.
// ----------------------------------------------------------------------------
module rslm_queue import rslm_pkg::*; #(
    parameter int WIDTH = SUM_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;

    logic w_do_push;
    logic w_do_pop;

    assign o_valid   = (r_fill != '0);
    assign o_full    = (r_fill == CNT_W'(DEPTH));
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/rslm_divider.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter divider
// Radix-2 restoring divider, one quotient bit per cycle, shared by the mean
// and the level quantizer.
// ----------------------------------------------------------------------------
module rslm_divider import rslm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SUM_W-1:0]     i_dividend,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [SUM_W-1:0]     o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [STEP_W-1:0]    r_steps;
    logic                 r_busy;
    logic                 r_done;

    logic [DIVISOR_W:0]   w_rem_shift;
    logic                 w_ge;
    logic [DIVISOR_W:0]   w_rem_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign w_rem_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge        = (w_rem_shift >= {1'b0, r_divisor});
    assign w_rem_sub   = w_rem_shift - {1'b0, r_divisor};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[DIVISOR_W-1:0] : w_rem_shift[DIVISOR_W-1:0];
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/rslm_back.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter back end
// Turns one finished window into a level item: mean, square root, volts,
// smoothing and quantization, then holds the item in the output register.
// ----------------------------------------------------------------------------
module rslm_back import rslm_pkg::*; #(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_cfg                                      i_cfg,
    input  logic                                      i_queue_valid,
    input  logic [SUM_W+$clog2(MAX_WINDOW+1)-1:0]     i_queue_data,
    output logic                                      o_queue_pop,
    output logic                                      o_div_start,
    output logic [SUM_W-1:0]                          o_div_dividend,
    output logic [DIVISOR_W-1:0]                      o_div_divisor,
    input  logic                                      i_div_done,
    input  logic [SUM_W-1:0]                          i_div_quotient,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [OUT_TDATA_W-1:0]                    o_data
);

    localparam int COUNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int K_W         = $clog2(SQRT_STEPS);
    localparam int D_W         = VOLTS_W;
    localparam int VOLT_SCALE  = VOLT_NUM_BASE << (Q16_SHIFT - SAMPLE_BITS);
    localparam int SMOOTH_W    = PRODUCT_W + 1;
    localparam int VPROD_W     = SUM_W + VOLT_RECIP_W;
    localparam int VQUO_W      = VPROD_W - VOLT_RECIP_SHIFT;

    t_back_state r_state;
    t_back_state n_state;

    logic [SUM_W-1:0]     r_x;
    logic [SUM_W-1:0]     r_res;
    logic [K_W-1:0]       r_k;
    logic [SUM_W-1:0]     r_numer;
    logic [VOLTS_W-1:0]   r_volts;
    logic [PRODUCT_W-1:0] r_p_new;
    logic [PRODUCT_W-1:0] r_p_old;
    logic [VOLTS_W-1:0]   r_prev;
    logic [VOLTS_W-1:0]   r_smooth;
    logic [LEVEL_W-1:0]   r_level;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [SUM_W-1:0]     w_q_sum;
    logic [COUNT_W-1:0]   w_q_count;
    logic [SUM_W-1:0]     w_sq_bit;
    logic [SUM_W:0]       w_sq_trial;
    logic                 w_sq_ge;
    logic [SUM_W-1:0]     w_x_next;
    logic [SUM_W-1:0]     w_res_next;
    logic [D_W-1:0]       w_two_r;
    logic [D_W-1:0]       w_full;
    logic [D_W-1:0]       w_dist;
    logic [SUM_W-1:0]     w_numer;
    logic [VPROD_W-1:0]   w_volt_prod;
    logic [VQUO_W-1:0]    w_volt_quo;
    logic [CFG_WEIGHT_W-1:0] w_weight;
    logic [CFG_WEIGHT_W-1:0] w_weight_old;
    logic [SMOOTH_W-1:0]  w_smooth_full;
    logic [VOLTS_W-1:0]   w_smooth;
    logic                 w_quiet;
    logic                 w_step_zero;
    logic                 w_out_load;

    assign w_q_sum   = i_queue_data[SUM_W-1:0];
    assign w_q_count = i_queue_data[SUM_W +: COUNT_W];

    // Square root step: test one result bit per cycle.
    assign w_sq_bit   = SUM_W'(1) << {r_k, 1'b0};
    assign w_sq_trial = {1'b0, r_res} + {1'b0, w_sq_bit};
    assign w_sq_ge    = ({1'b0, r_x} >= w_sq_trial);
    assign w_x_next   = w_sq_ge ? (r_x - w_sq_trial[SUM_W-1:0]) : r_x;
    assign w_res_next = w_sq_ge ? ((r_res >> 1) + w_sq_bit) : (r_res >> 1);

    // Distance of the rms code from mid scale, then scaled so that a divide
    // by ten gives Q2.16 volts rounded half up.
    assign w_two_r = {1'b0, r_res[SQRT_STEPS-1:0], 1'b0};
    assign w_full  = D_W'(1) << SAMPLE_BITS;
    assign w_dist  = (w_two_r >= w_full) ? (w_two_r - w_full) : (w_full - w_two_r);
    assign w_numer = SUM_W'(w_dist) * SUM_W'(VOLT_SCALE) + SUM_W'(VOLT_ROUND);

    // Divide by ten through the reciprocal multiply.
    assign w_volt_prod = VPROD_W'(r_numer) * VPROD_W'(VOLT_RECIP);
    assign w_volt_quo  = w_volt_prod[VPROD_W-1:VOLT_RECIP_SHIFT];

    // Smoothing weights, the new one saturated at one.
    assign w_weight     = (i_cfg.new_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.new_weight;
    assign w_weight_old = WEIGHT_ONE - w_weight;

    assign w_smooth_full = SMOOTH_W'(r_p_new) + SMOOTH_W'(r_p_old)
                         + SMOOTH_W'(SMOOTH_ROUND);
    assign w_smooth      = w_smooth_full[SMOOTH_SHIFT +: VOLTS_W];
    assign w_quiet       = (w_smooth < i_cfg.noise_threshold) || (w_smooth == '0);
    assign w_step_zero   = (i_cfg.level_step == '0);

    assign w_out_load = (r_state == BK_EMIT) && (!r_out_valid || i_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_queue_valid) n_state = BK_MEAN;
            BK_MEAN:  if (i_div_done) n_state = BK_SQRT;
            BK_SQRT:  if (r_k == '0) n_state = BK_SCALE;
            BK_SCALE: n_state = BK_VOLT;
            BK_VOLT:  n_state = BK_MIX;
            BK_MIX:   n_state = BK_SUM;
            BK_SUM: begin
                if (w_quiet || w_step_zero) begin
                    n_state = BK_EMIT;
                end else begin
                    n_state = BK_LEVEL;
                end
            end
            BK_LEVEL: if (i_div_done) n_state = BK_EMIT;
            BK_EMIT:  if (w_out_load) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop and divider requests.
    always_comb begin
        o_queue_pop    = 1'b0;
        o_div_start    = 1'b0;
        o_div_dividend = '0;
        o_div_divisor  = '0;
        unique case (r_state)
            BK_IDLE: begin
                o_queue_pop    = i_queue_valid;
                o_div_start    = i_queue_valid;
                o_div_dividend = w_q_sum;
                o_div_divisor  = DIVISOR_W'(w_q_count);
            end
            BK_SUM: begin
                o_div_start    = !(w_quiet || w_step_zero);
                o_div_dividend = SUM_W'(w_smooth - VOLTS_W'(1));
                o_div_divisor  = i_cfg.level_step;
            end
            BK_MEAN, BK_SQRT, BK_SCALE, BK_VOLT, BK_MIX, BK_LEVEL, BK_EMIT: begin
                o_div_start = 1'b0;
            end
            default: begin
                o_div_start = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window math datapath.
    always_ff @(posedge i_clk) begin
        if ((r_state == BK_MEAN) && i_div_done) begin
            r_x   <= i_div_quotient;
            r_res <= '0;
            r_k   <= K_W'(SQRT_STEPS - 1);
        end else if (r_state == BK_SQRT) begin
            r_x   <= w_x_next;
            r_res <= w_res_next;
            r_k   <= r_k - K_W'(1);
        end
        if (r_state == BK_SCALE) begin
            r_numer <= w_numer;
        end
        if (r_state == BK_VOLT) begin
            r_volts <= (w_volt_quo > VQUO_W'(VOLTS_MAX)) ? VOLTS_MAX
                                                        : w_volt_quo[VOLTS_W-1:0];
        end
        if (r_state == BK_MIX) begin
            r_p_new <= PRODUCT_W'(r_volts) * PRODUCT_W'(w_weight);
            r_p_old <= PRODUCT_W'(r_prev) * PRODUCT_W'(w_weight_old);
        end
        if (r_state == BK_SUM) begin
            r_smooth <= w_smooth;
            r_level  <= w_quiet ? '0 : LEVEL_MAX;
        end else if ((r_state == BK_LEVEL) && i_div_done) begin
            r_level <= (i_div_quotient > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : i_div_quotient[LEVEL_W-1:0];
        end
    end

    // Previous smoothed value carries from window to window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (r_state == BK_SUM) begin
            r_prev <= w_smooth;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {OUT_PAD_W'(0), r_smooth, r_level};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== rtl/rms_sound_level_meter.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter
// Windowed RMS of microphone samples, converted to volts, smoothed and
// quantized to a loudness level.
// ----------------------------------------------------------------------------
// The sample input takes one item per clock. Squares are summed in the front
// end; when a window closes, its sum and count go into a two-entry queue and
// the back end turns them into one level item: a divide for the mean, a
// 16-step square root, the distance from mid scale, the volt scaling by a
// reciprocal multiply, the smoothing and, unless the level is settled by the
// noise threshold or a zero step, another divide by the level step; both
// divides use the shared bit-serial divider. The input stalls only when a
// sample closes a window while the queue already holds two windows, that is,
// when the back end falls behind or level items are not taken promptly.
// Results wait in an output register and do not hold up new windows until the
// queue fills.
module rms_sound_level_meter import rslm_pkg::*; #(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample item: sample [SAMPLE_BITS-1:0], zero padded to bytes
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // level item: level [7:0], smoothed_volts [25:8], zeros [31:26]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [OUT_TDATA_W-1:0]             m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data
);

    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int QUEUE_W = SUM_W + COUNT_W;

    t_cfg r_cfg;

    logic                 w_push;
    logic [SUM_W-1:0]     w_push_sum;
    logic [COUNT_W-1:0]   w_push_count;
    logic                 w_queue_full;
    logic                 w_queue_valid;
    logic                 w_queue_pop;
    logic [QUEUE_W-1:0]   w_queue_data;
    logic                 w_div_start;
    logic [SUM_W-1:0]     w_div_dividend;
    logic [DIVISOR_W-1:0] w_div_divisor;
    logic                 w_div_done;
    logic [SUM_W-1:0]     w_div_quotient;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length   <= RST_WINDOW_LENGTH;
            r_cfg.noise_threshold <= RST_NOISE_THRESHOLD;
            r_cfg.level_step      <= RST_LEVEL_STEP;
            r_cfg.new_weight      <= RST_NEW_WEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WINDOW_LENGTH:   r_cfg.window_length   <= i_cfg_data[CFG_WINDOW_W-1:0];
                CFG_NOISE_THRESHOLD: r_cfg.noise_threshold <= i_cfg_data[CFG_VOLTS_W-1:0];
                CFG_LEVEL_STEP:      r_cfg.level_step      <= i_cfg_data[CFG_VOLTS_W-1:0];
                CFG_NEW_WEIGHT:      r_cfg.new_weight      <= i_cfg_data[CFG_WEIGHT_W-1:0];
                default:             r_cfg.window_length   <= r_cfg.window_length;
            endcase
        end
    end

    // Window accumulation.
    rslm_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_sample        (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_window_length (r_cfg.window_length),
        .i_queue_full    (w_queue_full),
        .o_push          (w_push),
        .o_push_sum      (w_push_sum),
        .o_push_count    (w_push_count)
    );

    // Finished windows waiting for the back end.
    rslm_queue #(
        .WIDTH (QUEUE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_count, w_push_sum}),
        .i_pop   (w_queue_pop),
        .o_valid (w_queue_valid),
        .o_full  (w_queue_full),
        .o_data  (w_queue_data)
    );

    // Shared divider.
    rslm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    // Per-window math and output register.
    rslm_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_queue_valid  (w_queue_valid),
        .i_queue_data   (w_queue_data),
        .o_queue_pop    (w_queue_pop),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .o_div_divisor  (w_div_divisor),
        .i_div_done     (w_div_done),
        .i_div_quotient (w_div_quotient),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata)
    );

endmodule

// ===== rtl/rslm_checker.sv =====
// ----------------------------------------------------------------------------
// RMS sound level meter checker
// Port-level assertions on the level item stream, bound to the top level.
// ----------------------------------------------------------------------------
module rslm_checker import rslm_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled level item keeps its value.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("level item changed while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("level item valid after reset");

    // A silent smoothed amplitude always quantizes to level zero.
    a_zero_volts_zero_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[LEVEL_W +: VOLTS_W] == '0))
            |-> (m_axis_tdata[LEVEL_W-1:0] == '0))
        else $error("nonzero level for zero amplitude");

    // Padding above the smoothed volts stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:LEVEL_W+VOLTS_W] == '0))
        else $error("padding bits set in level item");

endmodule

bind rms_sound_level_meter rslm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/rslm_level_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Level item checker for the RMS sound level meter
// Watches the sample, level and register write channels, keeps its own
// model of the windowed RMS, volt scaling, smoothing and quantization, and
// compares every level item with the oldest predicted one.
// ----------------------------------------------------------------------------
module rslm_level_checker import rslm_pkg::*; #(
    parameter int IN_TDATA_W = ((DEF_SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample channel: sample [11:0], zeros above
    input  logic                   i_smp_valid,
    input  logic                   i_smp_ready,
    input  logic [IN_TDATA_W-1:0]  i_smp_data,
    // level channel: level [7:0], smoothed_volts [25:8], zeros [31:26]
    input  logic                   i_lvl_valid,
    input  logic                   i_lvl_ready,
    input  logic [OUT_TDATA_W-1:0] i_lvl_data,
    // register writes
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int unsigned  FULL_SCALE = 1 << DEF_SAMPLE_BITS;
    localparam logic [63:0]  VOLT_DIV   = 64'd10 * FULL_SCALE;
    localparam logic [63:0]  VOLT_HALF  = VOLT_DIV / 2;
    localparam int           PRINT_CAP  = 100;

    // Level sits in the low bits, as on the level channel
    typedef struct packed {
        logic [VOLTS_W-1:0] volts;
        logic [LEVEL_W-1:0] level;
    } t_level_item;

    // Register copies, reset to the block's documented values
    logic [CFG_WINDOW_W-1:0] cfg_window = RST_WINDOW_LENGTH;
    logic [CFG_VOLTS_W-1:0]  cfg_thresh = RST_NOISE_THRESHOLD;
    logic [CFG_VOLTS_W-1:0]  cfg_step   = RST_LEVEL_STEP;
    logic [CFG_WEIGHT_W-1:0] cfg_weight = RST_NEW_WEIGHT;

    // Window accumulation and smoothing memory
    logic [SUM_W-1:0]   sum_sq     = '0;
    logic [8:0]         n_samples  = '0;
    logic [VOLTS_W-1:0] prev_volts = '0;

    t_level_item expected_levels[$];
    int          fails   = 0;
    int          checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // One line per mismatch; printing stops after a cap but counting goes on.
    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= PRINT_CAP) begin
            $display("%0t ns level check: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : predict_and_check
        t_level_item  got;
        t_level_item  want;
        logic [11:0]  smp;
        logic [31:0]  sq;
        logic [31:0]  mean;
        logic [15:0]  root;
        logic [15:0]  trial;
        logic [31:0]  quot;
        logic [63:0]  volts_q;
        logic [63:0]  mix;
        int unsigned  span;
        int unsigned  twice_r;
        int unsigned  offset;
        int unsigned  wt;

        if (!i_rst_n) begin
            cfg_window = RST_WINDOW_LENGTH;
            cfg_thresh = RST_NOISE_THRESHOLD;
            cfg_step   = RST_LEVEL_STEP;
            cfg_weight = RST_NEW_WEIGHT;
            sum_sq     = '0;
            n_samples  = '0;
            prev_volts = '0;
            expected_levels.delete();
        end else begin
            // Register writes land at the edge where the enable is high
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_WINDOW_LENGTH:   cfg_window = i_cfg_data[CFG_WINDOW_W-1:0];
                    CFG_NOISE_THRESHOLD: cfg_thresh = i_cfg_data[CFG_VOLTS_W-1:0];
                    CFG_LEVEL_STEP:      cfg_step   = i_cfg_data[CFG_VOLTS_W-1:0];
                    CFG_NEW_WEIGHT:      cfg_weight = i_cfg_data[CFG_WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // Compare first: a level item can never stem from a sample taken
            // at the same edge.
            if (i_lvl_valid && i_lvl_ready) begin
                got = i_lvl_data[LEVEL_W+VOLTS_W-1:0];
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("unexpected level item 0x%08h", i_lvl_data));
                end else begin
                    want = expected_levels.pop_front();
                    checked++;
                    if (got.level != want.level) begin
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  got.level, want.level));
                    end
                    if (got.volts != want.volts) begin
                        report_mismatch($sformatf("smoothed_volts %0d, expected %0d",
                                                  got.volts, want.volts));
                    end
                    if (i_lvl_data[OUT_TDATA_W-1:LEVEL_W+VOLTS_W] != '0) begin
                        report_mismatch($sformatf("nonzero padding in 0x%08h", i_lvl_data));
                    end
                end
            end

            // Accumulate the square of each accepted sample
            if (i_smp_valid && i_smp_ready) begin
                smp = i_smp_data[DEF_SAMPLE_BITS-1:0];
                sq  = smp * smp;
                if (sum_sq > 32'hFFFF_FFFF - sq) begin
                    sum_sq = '1;
                end else begin
                    sum_sq = sum_sq + sq;
                end
                n_samples = n_samples + 1'b1;

                // Zero means one sample; lengths above the maximum saturate.
                if (cfg_window == 0) begin
                    span = 1;
                end else if (cfg_window > DEF_MAX_WINDOW) begin
                    span = DEF_MAX_WINDOW;
                end else begin
                    span = cfg_window;
                end

                // A window ends once the count reaches the length, also when
                // the length was lowered below a count already gathered.
                if (n_samples >= span) begin
                    mean = sum_sq / n_samples;

                    // Floor square root, one result bit at a time
                    root = '0;
                    for (int b = 15; b >= 0; b--) begin
                        trial = root | (16'd1 << b);
                        if (32'(trial) * 32'(trial) <= mean) begin
                            root = trial;
                        end
                    end

                    // Distance from mid-scale, scaled to Q2.16 volts
                    twice_r = 2 * root;
                    offset  = (twice_r >= FULL_SCALE) ? twice_r - FULL_SCALE
                                                      : FULL_SCALE - twice_r;
                    volts_q = (64'd33 * 64'd65536 * offset + VOLT_HALF) / VOLT_DIV;
                    if (volts_q > 64'h3FFFF) begin
                        volts_q = 64'h3FFFF;
                    end

                    // Blend with the previous window's value
                    wt  = (cfg_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_weight;
                    mix = volts_q * wt + prev_volts * (256 - wt) + 128;
                    want.volts = mix[VOLTS_W+7:8];

                    // Quantize to a level
                    if (want.volts < cfg_thresh || want.volts == 0) begin
                        want.level = '0;
                    end else if (cfg_step == 0) begin
                        want.level = LEVEL_MAX;
                    end else begin
                        quot = (32'(want.volts) - 1) / cfg_step;
                        want.level = (quot > 255) ? LEVEL_MAX : quot[LEVEL_W-1:0];
                    end

                    prev_volts = want.volts;
                    sum_sq     = '0;
                    n_samples  = '0;
                    expected_levels.push_back(want);
                end
            end
        end

        o_fail_count <= fails;
        o_pending    <= expected_levels.size();
        o_checked    <= checked;
    end

endmodule

// ===== bench/tb_rms_sound_level_meter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RMS sound level meter
// Drives microphone samples and register settings with random gaps and
// output stalls; a side checker predicts and compares every level item.
// ----------------------------------------------------------------------------
module tb_rms_sound_level_meter;
    import rslm_pkg::*;

    localparam int IN_TDATA_W    = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 200;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int chk_fails;
    int lvl_pending;
    int lvl_checked;
    int samples_sent = 0;
    int settings     = 0;
    int rx_left      = 0;

    rms_sound_level_meter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rslm_level_checker u_level_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp_valid  (s_axis_tvalid),
        .i_smp_ready  (s_axis_tready),
        .i_smp_data   (s_axis_tdata),
        .i_lvl_valid  (m_axis_tvalid),
        .i_lvl_ready  (m_axis_tready),
        .i_lvl_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (chk_fails),
        .o_pending    (lvl_pending),
        .o_checked    (lvl_checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog for a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Level receiver: ready stretches alternate with stalls, mostly short.
    always @(posedge i_clk) begin
        if (rx_left > 0) begin
            rx_left <= rx_left - 1;
        end else if ($urandom_range(0, 9) < 6) begin
            m_axis_tready <= 1'b1;
            rx_left       <= $urandom_range(1, 40);
        end else begin
            m_axis_tready <= 1'b0;
            rx_left       <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
        end
    end

    // Gap after a sample: none in burst phases, else mostly short.
    function automatic int pick_gap(input bit bursty);
        int r;
        r = $urandom_range(0, 99);
        if (bursty || r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 50);
    endfunction

    // Sample around mid-scale within a spread, with some noise and rails.
    function automatic logic [11:0] pick_sample(input int spread);
        int r;
        int code;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 12'($urandom_range(0, 4095));
        end else if (r < 15) begin
            return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        end
        code = 2048 + $urandom_range(0, 2 * spread) - spread;
        if (code < 0) code = 0;
        if (code > 4095) code = 4095;
        return 12'(code);
    endfunction

    task automatic send_sample(input logic [11:0] smp, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every predicted level item has been taken.
    task automatic drain_levels;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (lvl_pending != 0) @(posedge i_clk);
    endtask

    task automatic settle;
        drain_levels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        settings++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int win, input int thr, input int step, input int wt);
        settle();
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(win));
        write_reg(CFG_NOISE_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_LEVEL_STEP, CFG_DATA_W'(step));
        write_reg(CFG_NEW_WEIGHT, CFG_DATA_W'(wt));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int spread, input bit bursty);
        for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(spread), pick_gap(bursty));
        end
    endtask

    // Random register setting with its extremes drawn now and then.
    task automatic random_setting;
        int win;
        int thr;
        int step;
        int wt;
        case ($urandom_range(0, 9))
            0:       win = 0;
            1:       win = 1;
            7:       win = $urandom_range(13, 40);
            8:       win = $urandom_range(257, 511);
            9:       win = $urandom_range(1, 6);
            default: win = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 3))
            0:       thr = 0;
            1:       thr = 262143;
            default: thr = $urandom_range(0, 60000);
        endcase
        case ($urandom_range(0, 5))
            0:       step = 0;
            1:       step = 1;
            2:       step = 262143;
            default: step = $urandom_range(1, 4000);
        endcase
        case ($urandom_range(0, 4))
            0:       wt = 0;
            1:       wt = 256;
            2:       wt = $urandom_range(257, 511);
            default: wt = $urandom_range(1, 255);
        endcase
        apply_setting(win, thr, step, wt);
    endtask

    // Stimulus
    initial begin
        logic [11:0] rail_codes[9];
        rail_codes = '{12'h000, 12'hFFF, 12'h800, 12'h7FF, 12'h801,
                       12'h001, 12'hFFE, 12'h555, 12'hAAA};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-sample windows with the other registers at their reset values
        settle();
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(1));
        i_cfg_we <= 1'b0;
        foreach (rail_codes[k]) send_sample(rail_codes[k], pick_gap(1'b0));

        // No smoothing, no threshold, finest step: full swing, then silence
        apply_setting(1, 0, 1, 256);
        send_sample(12'h000, 0);
        send_sample(12'h800, 0);
        send_sample(12'h834, 0);

        // Zero step saturates any nonzero level
        apply_setting(1, 0, 0, 256);
        send_sample(12'h800, 0);
        send_sample(12'h000, 0);

        // Zero window acts as one; zero weight holds the previous value
        apply_setting(0, 0, 0, 0);
        send_sample(12'h800, 0);
        send_sample(12'h064, 0);

        // Oversized weight saturates; top threshold silences the level
        apply_setting(1, 262143, 262143, 511);
        send_sample(12'hBB8, 0);

        // Two-sample windows at half weight
        apply_setting(2, 0, 1, 128);
        send_sample(12'h000, 0);
        send_sample(12'hFFF, 0);
        send_sample(12'hFFF, 0);
        send_sample(12'h800, 0);

        // Power-on style setting; leaves a partly filled window behind
        apply_setting(int'(RST_WINDOW_LENGTH), int'(RST_NOISE_THRESHOLD),
                      int'(RST_LEVEL_STEP), int'(RST_NEW_WEIGHT));
        run_phase(210, 1500, 1'b0);

        // A shorter window closes on the very next sample
        apply_setting(3, 3000, 1000, 200);
        run_phase(40, 1200, 1'b1);

        // Oversized window saturates to the maximum, loud content with the widest spread
        apply_setting(511, 0, 500, 64);
        run_phase(256, 2047, 1'b0);

        // Random settings, amplitudes and pacing
        repeat (6) begin
            random_setting();
            run_phase(40, $urandom_range(0, 2047), $urandom_range(0, 3) == 0);
        end

        drain_levels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples over %0d register settings, %0d level items checked",
                 samples_sent, settings, lvl_checked);
        if (lvl_pending != 0) begin
            $display("summary: %0d predicted level items never arrived", lvl_pending);
        end
        if (chk_fails == 0 && lvl_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
